// ----- hdl/spgt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sharing-group table package
// Sizes, operation codes and status codes shared by the table modules.
// ----------------------------------------------------------------------------
package spgt_pkg;

    localparam int NumGroups     = 64;
    localparam int PagesPerGroup = 128;
    localparam int SlotW  = $clog2(NumGroups);
    localparam int PageW  = $clog2(PagesPerGroup);
    localparam int FillW  = $clog2(PagesPerGroup + 1);
    localparam int StoreW = SlotW + PageW;
    localparam int AddrW  = 56;
    localparam int GidW   = 15;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_ADD    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_READ   = 3'd3,
        OP_INC    = 3'd4,
        OP_DEC    = 3'd5,
        OP_ERASE  = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONE   = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOSLOT = 2'd3
    } status_t;

endpackage : spgt_pkg
`default_nettype wire

// ----- hdl/spgt_page_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Page store RAM
// Single-port synchronous RAM holding every group's page list, registered read.
// ----------------------------------------------------------------------------
module spgt_page_ram
    import spgt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [StoreW-1:0] addr,
    input  wire logic [AddrW-1:0]  wr_data,
    output logic      [AddrW-1:0]  rd_data
);

    logic [AddrW-1:0] mem [NumGroups*PagesPerGroup];

    // write when enabled; read data is always registered, old contents on a write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule : spgt_page_ram
`default_nettype wire

// ----- hdl/shared_page_group_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sharing-group table
// Table of sharing groups, each with an id, member count and page list.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Slot allocation scans the used flags one
// per cycle, and a check past the last slot finds the table full. Group
// lookup reads the slot table one entry per cycle and compares the entry read
// the cycle before. Add and query with a nonzero page address then walk the
// group's page list in the page RAM, one read per cycle, compare the last read
// and finish in the wait state; a list holds up to 128 pages. Count operations
// and erase finish after the lookup; clear all and a negative group id go
// straight to the result. The worst case is an add or query on the last slot
// with a full list. One request is handled at a time; a finished result sits
// in the output register while s_tready stays low until it is taken.
module shared_page_group_table
    import spgt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // kind[2:0], group_id[18:3], page_address[74:19]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // is_shared[0], member_count[8:1], status[10:9]
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WALK, S_WAIT, S_OUT} state_t;

    state_t state_reg;
    logic [NumGroups-1:0] used_reg;
    logic [GidW-1:0]  group_mem   [NumGroups];
    logic [7:0]       members_mem [NumGroups];
    logic [FillW-1:0] fill_mem    [NumGroups];

    op_t              op_reg;
    logic [GidW-1:0]  gid_reg;
    logic [AddrW-1:0] pa_reg;
    logic [SlotW:0]   scan_reg;
    logic [SlotW-1:0] slot_reg;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] idx_reg;
    logic             rd_pend_reg;
    logic             hit_reg;
    logic [7:0]       cnt_reg;
    logic             shared_reg;
    status_t          status_reg;

    logic             look_vld_reg;
    logic [SlotW-1:0] look_idx_reg;
    logic [GidW-1:0]  group_rd_reg;
    logic [7:0]       members_rd_reg;
    logic [FillW-1:0] fill_rd_reg;

    logic [SlotW-1:0] scan_idx;
    logic             ram_we;
    logic [StoreW-1:0] ram_addr;
    logic [AddrW-1:0]  ram_q;

    assign scan_idx  = scan_reg[SlotW-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, status_reg, cnt_reg, shared_reg};

    // page RAM access: walk reads, append writes at the fill position
    assign ram_we = (state_reg == S_WAIT) && !hit_reg && (op_reg == OP_ADD)
                    && (fill_reg < FillW'(PagesPerGroup));
    assign ram_addr = ram_we ? {slot_reg, fill_reg[PageW-1:0]}
                             : {slot_reg, idx_reg[PageW-1:0]};

    spgt_page_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .addr    (ram_addr),
        .wr_data (pa_reg),
        .rd_data (ram_q)
    );

    // slot table read port, registered
    always_ff @(posedge aclk) begin
        group_rd_reg   <= group_mem[scan_idx];
        members_rd_reg <= members_mem[scan_idx];
        fill_rd_reg    <= fill_mem[scan_idx];
    end

    // sequencer with registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= op_t'(s_tdata[2:0]);
                        gid_reg      <= s_tdata[17:3];
                        pa_reg       <= s_tdata[74:19];
                        scan_reg     <= '0;
                        look_vld_reg <= 1'b0;
                        shared_reg   <= 1'b0;
                        cnt_reg      <= '0;
                        status_reg   <= ST_OK;
                        if (op_t'(s_tdata[2:0]) == OP_CLEAR) begin
                            used_reg  <= '0;
                            state_reg <= S_OUT;
                        end else if (s_tdata[18]) begin
                            status_reg <= ST_NONE;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (op_reg == OP_CREATE) begin
                        // first free slot from the used flags
                        if (scan_reg == (SlotW+1)'(NumGroups)) begin
                            status_reg <= ST_NOSLOT;
                            state_reg  <= S_OUT;
                        end else if (!used_reg[scan_idx]) begin
                            used_reg[scan_idx]    <= 1'b1;
                            group_mem[scan_idx]   <= gid_reg;
                            members_mem[scan_idx] <= '0;
                            fill_mem[scan_idx]    <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end else if (look_vld_reg && used_reg[look_idx_reg]
                                 && group_rd_reg == gid_reg) begin
                        // slot read last cycle matches: lowest used slot wins
                        slot_reg    <= look_idx_reg;
                        fill_reg    <= fill_rd_reg;
                        idx_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        hit_reg     <= 1'b0;
                        cnt_reg     <= members_rd_reg;
                        case (op_reg)
                            OP_ADD, OP_QUERY: begin
                                if (pa_reg == '0) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_INC: begin
                                if (members_rd_reg != 8'hFF) begin
                                    members_mem[look_idx_reg] <= members_rd_reg + 1'b1;
                                    cnt_reg <= members_rd_reg + 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                            OP_DEC: begin
                                if (members_rd_reg != 8'd0) begin
                                    members_mem[look_idx_reg] <= members_rd_reg - 1'b1;
                                    cnt_reg <= members_rd_reg - 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                            OP_ERASE: begin
                                used_reg[look_idx_reg] <= 1'b0;
                                cnt_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end else if (scan_reg == (SlotW+1)'(NumGroups)) begin
                        status_reg <= ST_NONE;
                        state_reg  <= S_OUT;
                    end else begin
                        // read the next slot, compare it next cycle
                        scan_reg     <= scan_reg + 1'b1;
                        look_vld_reg <= 1'b1;
                        look_idx_reg <= scan_idx;
                    end
                end
                S_WALK: begin
                    // issue one read a cycle, compare the previous read
                    rd_pend_reg <= (idx_reg < fill_reg);
                    if (idx_reg < fill_reg) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_pend_reg && ram_q == pa_reg) begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_WAIT;
                    end else if (!(idx_reg < fill_reg)) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (op_reg == OP_QUERY) begin
                        shared_reg <= hit_reg;
                    end else if (!hit_reg) begin
                        if (fill_reg < FillW'(PagesPerGroup)) begin
                            fill_mem[slot_reg] <= fill_reg + 1'b1;
                        end else begin
                            status_reg <= ST_FULL;
                            cnt_reg    <= '0;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a result never reports a count alongside a fault
    a_cnt_zero_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != ST_OK) |-> (cnt_reg == 8'd0))
        else $error("count set on faulted result");

    // the page RAM is written only at the end of a walk
    a_write_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (state_reg == S_OUT))
        else $error("page write outside append");

    // shared flag only answers a query
    a_shared_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && shared_reg) |-> (op_reg == OP_QUERY && status_reg == ST_OK))
        else $error("shared flag on non-query");

endmodule : shared_page_group_table
`default_nettype wire
